@@ hdl/terq_pkg.sv @@
// Shared types and status codes for the timed event replay queue.
package terq_pkg;

    typedef enum logic [2:0] {
        ST_PUSHED   = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_WAIT     = 3'd3,
        ST_RELEASED = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [31:0] stamp;
        logic               is_reset;
        logic        [31:0] payload;
    } t_entry;

    localparam logic [30:0] DELAY_MAX = 31'h7FFF_FFFF;

endpackage

@@ hdl/timed_event_replay_queue.sv @@
// Top level of the timed event replay queue: event FIFO, head prefetch and replay timing.
//
// Throughput: one request per clock cycle; busy never rises, so any request is taken at once.
// A request passes the input register, then the result register, and the result strobe
// rises from the latter; the stage between them reads the prefetched queue head.
// Reset: synchronous, active low; clears pointers, count, both time bases (to unset) and the
// pipeline valid flags. The queue memory is not cleared and needs no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module timed_event_replay_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic               i_action,
    input  logic signed [31:0] i_now_time,
    input  logic signed [31:0] i_event_stamp,
    input  logic               i_event_is_reset,
    input  logic        [31:0] i_event_payload,
    output logic               o_valid,
    output logic        [2:0]  o_status,
    output logic        [30:0] o_wait_delay,
    output logic signed [31:0] o_out_stamp,
    output logic               o_out_is_reset,
    output logic        [31:0] o_out_payload
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // The block has no multi-cycle work, so it never holds a request off.
    assign o_busy = 1'b0;

    // Input register: the accepted request waits here while the queue head is read from memory.
    logic               r_in_valid;
    logic               r_in_action;
    logic signed [31:0] r_in_now;
    terq_pkg::t_entry   r_in_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_action           <= i_action;
        r_in_now              <= i_now_time;
        r_in_entry.stamp      <= i_event_stamp;
        r_in_entry.is_reset   <= i_event_is_reset;
        r_in_entry.payload    <= i_event_payload;
    end

    // Queue control state and time bases.
    logic        [PTR_W-1:0] r_head, n_head;
    logic        [PTR_W-1:0] r_tail, n_tail;
    logic        [CNT_W-1:0] r_count, n_count;
    logic signed [31:0]      r_time_base, n_time_base;
    logic signed [31:0]      r_motion_start, n_motion_start;

    // Queue memory. The read port always looks at the head that the next cycle will
    // use; a write to that same entry in this cycle is forwarded around the memory.
    terq_pkg::t_entry mem [QUEUE_DEPTH];
    terq_pkg::t_entry r_rd_data;
    terq_pkg::t_entry r_fwd_data;
    logic             r_fwd;
    logic             wr_en;
    terq_pkg::t_entry head_entry;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= r_in_entry;
        end
        r_rd_data  <= mem[n_head];
        r_fwd_data <= r_in_entry;
        r_fwd      <= wr_en && (r_tail == n_head);
    end

    assign head_entry = r_fwd ? r_fwd_data : r_rd_data;

    // Execute stage: all the work for one request, between the input and result registers.
    logic                 is_full;
    logic                 is_empty;
    logic signed [31:0]   ms_eff;
    logic signed [31:0]   tb_eff;
    logic signed [31:0]   elapsed;
    logic signed [31:0]   offset;
    logic        [32:0]   diff;
    logic                 due;
    terq_pkg::t_status    res_status;
    logic        [30:0]   res_delay;
    logic                 res_head;

    always_comb begin
        is_full  = (r_count == CNT_FULL);
        is_empty = (r_count == '0);

        // An unset base (zero or negative) is captured on a poll that finds an event.
        ms_eff = (r_motion_start[31] || (r_motion_start == '0)) ? r_in_now : r_motion_start;
        tb_eff = (r_time_base[31] || (r_time_base == '0)) ? head_entry.stamp : r_time_base;

        elapsed = r_in_now - ms_eff;
        offset  = head_entry.stamp - tb_eff;
        due     = (elapsed >= offset);
        diff    = {offset[31], offset} - {elapsed[31], elapsed};

        n_head         = r_head;
        n_tail         = r_tail;
        n_count        = r_count;
        n_time_base    = r_time_base;
        n_motion_start = r_motion_start;
        wr_en          = 1'b0;
        res_status     = terq_pkg::ST_PUSHED;
        res_delay      = '0;
        res_head       = 1'b0;

        if (r_in_valid) begin
            if (!r_in_action) begin
                if (is_full) begin
                    res_status = terq_pkg::ST_DROPPED;
                end else begin
                    wr_en      = 1'b1;
                    n_tail     = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                    n_count    = r_count + 1'b1;
                    res_status = terq_pkg::ST_PUSHED;
                end
            end else if (is_empty) begin
                res_status = terq_pkg::ST_EMPTY;
            end else begin
                res_head       = 1'b1;
                n_time_base    = tb_eff;
                n_motion_start = ms_eff;
                if (due) begin
                    if (head_entry.is_reset) begin
                        n_time_base    = head_entry.stamp;
                        n_motion_start = r_in_now;
                    end
                    n_head     = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                    n_count    = r_count - 1'b1;
                    res_status = terq_pkg::ST_RELEASED;
                end else begin
                    // The difference is positive here and may exceed the 31-bit range.
                    res_delay  = (diff[32:31] != 2'b00) ? terq_pkg::DELAY_MAX : diff[30:0];
                    res_status = terq_pkg::ST_WAIT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_time_base    <= -32'sd1;
            r_motion_start <= -32'sd1;
        end else begin
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_time_base    <= n_time_base;
            r_motion_start <= n_motion_start;
        end
    end

    // Result register: one strobed result per request.
    logic               r_out_valid;
    terq_pkg::t_status  r_out_status;
    logic        [30:0] r_out_delay;
    terq_pkg::t_entry   r_out_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= res_status;
        r_out_delay  <= res_delay;
        r_out_entry  <= res_head ? head_entry : '0;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_wait_delay   = r_out_delay;
    assign o_out_stamp    = r_out_entry.stamp;
    assign o_out_is_reset = r_out_entry.is_reset;
    assign o_out_payload  = r_out_entry.payload;

endmodule

@@ test/terq_tb_pkg.sv @@
// Request action codes shared by the replay queue testbench modules.
package terq_tb_pkg;

    typedef enum logic {
        ACTION_PUSH = 1'b0,
        ACTION_POLL = 1'b1
    } t_action;

endpackage

@@ test/timed_event_replay_queue_checker.sv @@
// Predicts and checks every result of the timed event replay queue.
module timed_event_replay_queue_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic               i_action,
    input  logic signed [31:0] i_now_time,
    input  logic signed [31:0] i_event_stamp,
    input  logic               i_event_is_reset,
    input  logic        [31:0] i_event_payload,
    input  logic               i_valid,
    input  logic        [2:0]  i_status,
    input  logic        [30:0] i_wait_delay,
    input  logic signed [31:0] i_out_stamp,
    input  logic               i_out_is_reset,
    input  logic        [31:0] i_out_payload,
    output int                 o_error_count,
    output int                 o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        terq_pkg::t_status  status;
        logic        [30:0] wait_delay;
        logic signed [31:0] stamp;
        logic               is_reset;
        logic        [31:0] payload;
    } t_replay_result;

    terq_pkg::t_entry   event_fifo [QUEUE_DEPTH];
    int unsigned        head_idx;
    int unsigned        tail_idx;
    int unsigned        fill_level;
    logic signed [31:0] time_base;
    logic signed [31:0] motion_start;
    t_replay_result     due_results [$];
    t_replay_result     predicted;
    int                 error_tally = 0;

    // Applies one request to the mirrored queue and time bases.
    function automatic t_replay_result replay_step(input logic action,
                                                   input logic signed [31:0] now,
                                                   input logic signed [31:0] stamp,
                                                   input logic is_reset,
                                                   input logic [31:0] payload);
        t_replay_result     r;
        terq_pkg::t_entry   head;
        logic signed [31:0] head_stamp;
        logic signed [31:0] elapsed;
        logic signed [31:0] offset;
        longint             remaining;
        r = '{status: terq_pkg::ST_PUSHED, wait_delay: '0, stamp: '0, is_reset: 1'b0,
              payload: '0};
        if (action == terq_tb_pkg::ACTION_PUSH) begin
            if (fill_level >= QUEUE_DEPTH) begin
                r.status = terq_pkg::ST_DROPPED;
            end else begin
                event_fifo[tail_idx] = '{stamp: stamp, is_reset: is_reset, payload: payload};
                tail_idx = (tail_idx + 1) % QUEUE_DEPTH;
                fill_level++;
            end
        end else if (fill_level == 0) begin
            r.status = terq_pkg::ST_EMPTY;
        end else begin
            head = event_fifo[head_idx];
            head_stamp = head.stamp;
            // A time base below one counts as unset and is captured now.
            if (motion_start < 1) motion_start = now;
            if (time_base < 1) time_base = head_stamp;
            elapsed = now - motion_start;
            offset = head_stamp - time_base;
            r.stamp = head_stamp;
            r.is_reset = head.is_reset;
            r.payload = head.payload;
            if (elapsed >= offset) begin
                if (head.is_reset) begin
                    time_base = head_stamp;
                    motion_start = now;
                end
                head_idx = (head_idx + 1) % QUEUE_DEPTH;
                fill_level--;
                r.status = terq_pkg::ST_RELEASED;
            end else begin
                remaining = longint'(offset) - longint'(elapsed);
                if (remaining > longint'(terq_pkg::DELAY_MAX)) begin
                    r.wait_delay = terq_pkg::DELAY_MAX;
                end else begin
                    r.wait_delay = remaining[30:0];
                end
                r.status = terq_pkg::ST_WAIT;
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            error_tally++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            fill_level = 0;
            time_base = -32'sd1;
            motion_start = -32'sd1;
            due_results.delete();
        end else begin
            if (i_valid) begin
                if (due_results.size() == 0) begin
                    error_tally++;
                    $display("%0t: unexpected result, expected none, actual status %h",
                             $time, i_status);
                end else begin
                    predicted = due_results.pop_front();
                    check_field("status", predicted.status, i_status);
                    check_field("wait_delay", predicted.wait_delay, i_wait_delay);
                    check_field("out_stamp", predicted.stamp, i_out_stamp);
                    check_field("out_is_reset", predicted.is_reset, i_out_is_reset);
                    check_field("out_payload", predicted.payload, i_out_payload);
                end
            end
            if (i_start && !i_busy) begin
                due_results.push_back(replay_step(i_action, i_now_time, i_event_stamp,
                                                  i_event_is_reset, i_event_payload));
            end
        end
        o_error_count <= error_tally;
        o_outstanding <= due_results.size();
    end

endmodule

@@ test/timed_event_replay_queue_test.sv @@
// Top of the replay queue testbench: clock, reset, request stimulus and verdict.
module timed_event_replay_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_start = 1'b0;
    logic               i_action = 1'b0;
    logic signed [31:0] i_now_time = '0;
    logic signed [31:0] i_event_stamp = '0;
    logic               i_event_is_reset = 1'b0;
    logic        [31:0] i_event_payload = '0;
    logic               o_busy;
    logic               o_valid;
    logic        [2:0]  o_status;
    logic        [30:0] o_wait_delay;
    logic signed [31:0] o_out_stamp;
    logic               o_out_is_reset;
    logic        [31:0] o_out_payload;
    int                 error_count;
    int                 outstanding;

    timed_event_replay_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_action        (i_action),
        .i_now_time      (i_now_time),
        .i_event_stamp   (i_event_stamp),
        .i_event_is_reset(i_event_is_reset),
        .i_event_payload (i_event_payload),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_wait_delay    (o_wait_delay),
        .o_out_stamp     (o_out_stamp),
        .o_out_is_reset  (o_out_is_reset),
        .o_out_payload   (o_out_payload)
    );

    // The checker sees the same request and result wires as the block and keeps
    // its own model of the queue, so this module only drives stimulus.
    timed_event_replay_queue_checker #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_action        (i_action),
        .i_now_time      (i_now_time),
        .i_event_stamp   (i_event_stamp),
        .i_event_is_reset(i_event_is_reset),
        .i_event_payload (i_event_payload),
        .i_valid         (o_valid),
        .i_status        (o_status),
        .i_wait_delay    (o_wait_delay),
        .i_out_stamp     (o_out_stamp),
        .i_out_is_reset  (o_out_is_reset),
        .i_out_payload   (o_out_payload),
        .o_error_count   (error_count),
        .o_outstanding   (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // Issues one request. Before it, every cycle is an idle cycle with the given
    // chance, so about that share of the sender's cycles carry no request;
    // otherwise start stays high from the previous request, so back-to-back
    // requests never see start lowered and raised in one step.
    task automatic send_request(input terq_tb_pkg::t_action act,
                                input logic signed [31:0] now_t,
                                input logic signed [31:0] stamp, input logic is_reset,
                                input logic [31:0] payload, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_action <= act;
        i_now_time <= now_t;
        i_event_stamp <= stamp;
        i_event_is_reset <= is_reset;
        i_event_payload <= payload;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    // Holds off new requests until the checker has seen every predicted result.
    // The outstanding count is registered, hence the first wait.
    task automatic wait_for_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: pushed stamps and poll times each march
    // forward from their own clock, so heads come due and reset markers rebase.
    // The push share changes every hundred requests so the queue alternately
    // fills up to drops and drains down to empty polls. About one request in
    // seven is pure noise with every field random.
    task automatic run_random_phase(input int item_total, input int idle_pct,
                                    input logic signed [31:0] clock_seed);
        logic signed [31:0] record_clock;
        logic signed [31:0] replay_clock;
        int                 push_pct;
        record_clock = clock_seed;
        replay_clock = clock_seed;
        push_pct = 50;
        for (int n = 0; n < item_total; n++) begin
            if (n % 100 == 0) push_pct = 20 + 20 * $urandom_range(3);
            if ($urandom_range(99) < 15) begin
                send_request(terq_tb_pkg::t_action'($urandom_range(1)), $urandom, $urandom,
                             $urandom_range(1), $urandom, idle_pct);
            end else if ($urandom_range(99) < push_pct) begin
                record_clock += $urandom_range(40);
                send_request(terq_tb_pkg::ACTION_PUSH, $urandom, record_clock,
                             $urandom_range(11) == 0, $urandom, idle_pct);
            end else begin
                replay_clock += $urandom_range(40);
                send_request(terq_tb_pkg::ACTION_POLL, replay_clock, $urandom,
                             $urandom_range(1), $urandom, idle_pct);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A poll of the empty queue leaves the unset time bases alone.
        send_request(terq_tb_pkg::ACTION_POLL, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 0);
        // The first poll captures both unset bases, so the head is due at once.
        send_request(terq_tb_pkg::ACTION_PUSH, 32'h0, 32'sd100, 1'b0, 32'h0, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'sd50, 32'h0, 1'b0, 32'h0, 0);
        // A far-off reset marker waits, then is released after the time wraps.
        send_request(terq_tb_pkg::ACTION_PUSH, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'sd51, 32'h0, 1'b0, 32'h0, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 0);
        // After the rebase the motion start is negative and is captured again.
        // The recorded offset wraps, and an elapsed time far in the past drives
        // the wait past its largest value so that it saturates.
        send_request(terq_tb_pkg::ACTION_PUSH, 32'h0, 32'hFFFF_FFFB, 1'b0, 32'hA5A5_A5A5, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'sd1000, 32'h0, 1'b0, 32'h0, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'sd999, 32'h0, 1'b0, 32'h0, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'h8000_03E8, 32'h0, 1'b0, 32'h0, 0);
        send_request(terq_tb_pkg::ACTION_POLL, 32'h8000_03E4, 32'h0, 1'b0, 32'h0, 0);
        // Fill the queue to the brim; one more push is dropped.
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            send_request(terq_tb_pkg::ACTION_PUSH, 32'hFFFF_FFFF, 32'h8000_0000 + k, k == 0,
                         32'h5A5A_0000 | k, 0);
        end
        send_request(terq_tb_pkg::ACTION_PUSH, 32'h0, 32'h7FFF_FFFF, 1'b1, 32'hDEAD_BEEF, 0);
        wait_for_results();

        run_random_phase(608, 24, $urandom_range(1, 1 << 20));
        wait_for_results();
        run_random_phase(608, 55, $urandom_range(1, 1 << 20));
        wait_for_results();
        // The last phase starts just below the signed limit so both clocks wrap.
        run_random_phase(608, 0, 32'h7FFF_F000);
        wait_for_results();

        // The extra wait catches any stray result.
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Guards against a hang; a correct run needs well under a tenth of this.
    initial begin
        #(5ms);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
